/* sv/dpid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_pkg: shared types and constants of the differential drive PID
// Register indexes, reset values, the control word layout and the microcode
// program that the sequencer steps through.
// ----------------------------------------------------------------------------
package dpid_pkg;

	localparam int COUNT_BITS_DEF = 6;
	localparam int PULSE_BITS_DEF = 12;
	localparam int SUM_BITS_DEF   = 24;

	localparam int GAIN_BITS      = 16;
	localparam int COEFF_FRAC     = 8;
	localparam int CORR_BITS      = 16;
	localparam int MAG_BITS       = 33;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [GAIN_BITS-1:0] GAIN_RESET   = 16'd1280;
	localparam logic [GAIN_BITS-1:0] ICOEFF_RESET = 16'd31;
	localparam logic [GAIN_BITS-1:0] DCOEFF_RESET = 16'd533;
	localparam int                   BASE_PULSE_RESET = 1650;

	localparam logic [MAG_BITS-1:0] MAG_LIMIT    = 33'h1_0000_0000;
	localparam logic [MAG_BITS-1:0] CORR_POS_MAX = 33'd32767;
	localparam logic [MAG_BITS-1:0] CORR_NEG_MAX = 33'd32768;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INT_COEFF  = 2'd1,
		REG_DER_COEFF  = 2'd2,
		REG_BASE_PULSE = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_SUM_IC,
		MUL_DIFF_DC,
		MUL_MAG_GAIN
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD_ERR,
		ACC_ADD_PROD
	} acc_op_t;

	typedef enum logic [1:0] {
		COND_NEXT,
		COND_IN_VALID,
		COND_OUT_FREE
	} cond_t;

	localparam int STEP_BITS = 4;
	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t STEP_WAIT    = 4'd0;
	localparam step_t STEP_ERR_SUM = 4'd1;
	localparam step_t STEP_MUL_I   = 4'd2;
	localparam step_t STEP_MUL_D   = 4'd3;
	localparam step_t STEP_ADD_D   = 4'd4;
	localparam step_t STEP_MAG     = 4'd5;
	localparam step_t STEP_MUL_K   = 4'd6;
	localparam step_t STEP_CORR    = 4'd7;
	localparam step_t STEP_OUT     = 4'd8;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     sum_upd;
		logic     prev_upd;
		logic     mag_en;
		logic     corr_en;
		logic     out_en;
		cond_t    cond;
		step_t    target;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} seq_stat_t;

	// Microcode ROM: one control word per step
	function automatic ctrl_t microcode(step_t s);
		ctrl_t c;
		c = '0;
		c.mul_sel = MUL_NONE;
		c.acc_op  = ACC_HOLD;
		c.cond    = COND_NEXT;
		c.target  = STEP_WAIT;
		unique case (s)
			STEP_WAIT: begin
				c.cond   = COND_IN_VALID;
				c.target = STEP_ERR_SUM;
			end
			STEP_ERR_SUM: begin
				c.sum_upd = 1'b1;
				c.acc_op  = ACC_LOAD_ERR;
			end
			STEP_MUL_I: begin
				c.mul_sel = MUL_SUM_IC;
			end
			STEP_MUL_D: begin
				c.acc_op   = ACC_ADD_PROD;
				c.mul_sel  = MUL_DIFF_DC;
				c.prev_upd = 1'b1;
			end
			STEP_ADD_D: begin
				c.acc_op = ACC_ADD_PROD;
			end
			STEP_MAG: begin
				c.mag_en = 1'b1;
			end
			STEP_MUL_K: begin
				c.mul_sel = MUL_MAG_GAIN;
			end
			STEP_CORR: begin
				c.corr_en = 1'b1;
			end
			STEP_OUT: begin
				c.out_en = 1'b1;
				c.cond   = COND_OUT_FREE;
				c.target = STEP_WAIT;
			end
			default: begin
				c.cond   = COND_IN_VALID;
				c.target = STEP_ERR_SUM;
			end
		endcase
		return c;
	endfunction

endpackage

/* sv/dpid_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_in_if: control tick channel
// Setpoint and wheel pulse counts of one tick, with valid/ready.
// ----------------------------------------------------------------------------
interface dpid_in_if #(
	parameter int COUNT_BITS = dpid_pkg::COUNT_BITS_DEF
) ();
	logic                   valid;
	logic                   ready;
	logic signed [COUNT_BITS:0] target_difference;
	logic [COUNT_BITS-1:0]  right_count;
	logic [COUNT_BITS-1:0]  left_count;

	modport source (output valid, output target_difference, output right_count,
		output left_count, input ready);
	modport sink (input valid, input target_difference, input right_count,
		input left_count, output ready);
endinterface

/* sv/dpid_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_out_if: servo pulse channel
// Left and right pulse widths, correction and clip flag, with valid/ready.
// ----------------------------------------------------------------------------
interface dpid_out_if #(
	parameter int PULSE_BITS = dpid_pkg::PULSE_BITS_DEF
) ();
	logic                                 valid;
	logic                                 ready;
	logic [PULSE_BITS-1:0]                left_pulse_us;
	logic [PULSE_BITS-1:0]                right_pulse_us;
	logic signed [dpid_pkg::CORR_BITS-1:0] correction;
	logic                                 clipped;

	modport source (output valid, output left_pulse_us, output right_pulse_us,
		output correction, output clipped, input ready);
	modport sink (input valid, input left_pulse_us, input right_pulse_us,
		input correction, input clipped, output ready);
endinterface

/* sv/dpid_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_seq: microcode sequencer
// Step counter over the control ROM, with conditional jumps on handshakes.
// ----------------------------------------------------------------------------
module dpid_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  dpid_pkg::seq_stat_t stat,
	output dpid_pkg::ctrl_t    ctrl
);

	dpid_pkg::step_t step_q;
	dpid_pkg::step_t step_d;

	assign ctrl = dpid_pkg::microcode(step_q);

	always_comb begin
		unique case (ctrl.cond)
			dpid_pkg::COND_NEXT:     step_d = step_q + dpid_pkg::STEP_BITS'(1);
			dpid_pkg::COND_IN_VALID: step_d = stat.in_valid ? ctrl.target : step_q;
			dpid_pkg::COND_OUT_FREE: step_d = stat.out_free ? ctrl.target : step_q;
			default:                 step_d = dpid_pkg::STEP_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dpid_pkg::STEP_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

/* sv/dpid_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_dp: PID datapath
// Error, integral and derivative state, one shared multiplier, accumulator
// and the saturation of integral sum, correction and pulse widths.
// ----------------------------------------------------------------------------
module dpid_dp #(
	parameter int COUNT_BITS = dpid_pkg::COUNT_BITS_DEF,
	parameter int PULSE_BITS = dpid_pkg::PULSE_BITS_DEF,
	parameter int SUM_BITS   = dpid_pkg::SUM_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dpid_pkg::ctrl_t                      ctrl,
	input  logic                                 accept,
	input  logic signed [COUNT_BITS:0]           target_difference,
	input  logic [COUNT_BITS-1:0]                right_count,
	input  logic [COUNT_BITS-1:0]                left_count,
	input  logic [dpid_pkg::GAIN_BITS-1:0]       gain,
	input  logic [dpid_pkg::GAIN_BITS-1:0]       icoeff,
	input  logic [dpid_pkg::GAIN_BITS-1:0]       dcoeff,
	input  logic [PULSE_BITS-1:0]                base,
	output logic [PULSE_BITS-1:0]                left_pulse_us,
	output logic [PULSE_BITS-1:0]                right_pulse_us,
	output logic signed [dpid_pkg::CORR_BITS-1:0] correction,
	output logic                                 clipped
);

	localparam int ERR_BITS   = COUNT_BITS + 2;
	localparam int DIFF_BITS  = ERR_BITS + 1;
	localparam int A_MAX1     = (SUM_BITS > DIFF_BITS) ? SUM_BITS : DIFF_BITS;
	localparam int MUL_A_BITS = (A_MAX1 > dpid_pkg::MAG_BITS + 1) ?
		A_MAX1 : dpid_pkg::MAG_BITS + 1;
	localparam int MUL_B_BITS = dpid_pkg::GAIN_BITS + 1;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
	localparam int SSUM_BITS  = ((SUM_BITS > ERR_BITS) ? SUM_BITS : ERR_BITS) + 1;
	localparam int PSUM_BITS  = ((PULSE_BITS > dpid_pkg::CORR_BITS) ?
		PULSE_BITS : dpid_pkg::CORR_BITS) + 2;
	localparam int CB         = dpid_pkg::CORR_BITS;
	localparam int MB         = dpid_pkg::MAG_BITS;

	logic signed [ERR_BITS-1:0]   err_q;
	logic signed [ERR_BITS-1:0]   prev_q;
	logic signed [SUM_BITS-1:0]   sum_q;
	logic signed [PROD_BITS-1:0]  acc_q;
	logic signed [PROD_BITS-1:0]  prod_q;
	logic [MB-1:0]                mag_q;
	logic                         neg_q;
	logic signed [CB-1:0]         corr_q;
	logic                         clip_q;

	logic signed [ERR_BITS-1:0]   err_new;
	logic signed [SSUM_BITS-1:0]  ssum;
	logic [SSUM_BITS-SUM_BITS:0]  ssum_top;
	logic                         sum_sat;
	logic signed [SUM_BITS-1:0]   sum_new;
	logic signed [DIFF_BITS-1:0]  diff;
	logic signed [MUL_A_BITS-1:0] mul_a;
	logic signed [MUL_B_BITS-1:0] mul_b;
	logic signed [PROD_BITS-1:0]  abs_acc;
	logic                         mag_big;
	logic [MB-1:0]                prod_k;
	logic signed [CB-1:0]         corr_new;
	logic                         corr_sat;
	logic signed [PSUM_BITS-1:0]  pbase;
	logic signed [PSUM_BITS-1:0]  pcorr;
	logic signed [PSUM_BITS-1:0]  left_s;
	logic signed [PSUM_BITS-1:0]  right_s;
	logic                         left_clip;
	logic                         right_clip;

	assign err_new = ERR_BITS'(target_difference)
		- (ERR_BITS'({1'b0, right_count}) - ERR_BITS'({1'b0, left_count}));

	// Saturating integral update: overflow when the top bits disagree
	assign ssum     = SSUM_BITS'(sum_q) + SSUM_BITS'(err_q);
	assign ssum_top = ssum[SSUM_BITS-1:SUM_BITS-1];
	assign sum_sat  = !((&ssum_top) || !(|ssum_top));
	always_comb begin
		if (!sum_sat) begin
			sum_new = ssum[SUM_BITS-1:0];
		end else if (ssum[SSUM_BITS-1]) begin
			sum_new = {1'b1, {(SUM_BITS-1){1'b0}}};
		end else begin
			sum_new = {1'b0, {(SUM_BITS-1){1'b1}}};
		end
	end

	assign diff = DIFF_BITS'(err_q) - DIFF_BITS'(prev_q);

	always_comb begin
		unique case (ctrl.mul_sel)
			dpid_pkg::MUL_SUM_IC: begin
				mul_a = MUL_A_BITS'(sum_q);
				mul_b = {1'b0, icoeff};
			end
			dpid_pkg::MUL_DIFF_DC: begin
				mul_a = MUL_A_BITS'(diff);
				mul_b = {1'b0, dcoeff};
			end
			dpid_pkg::MUL_MAG_GAIN: begin
				mul_a = MUL_A_BITS'({1'b0, mag_q});
				mul_b = {1'b0, gain};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Magnitude, clamped to 2^32: any non-zero gain saturates beyond it
	assign abs_acc = acc_q[PROD_BITS-1] ? -acc_q : acc_q;
	assign mag_big = (|abs_acc[PROD_BITS-1:MB])
		|| (abs_acc[MB-1] && (|abs_acc[MB-2:0]));

	assign prod_k = prod_q[dpid_pkg::GAIN_BITS +: MB];
	always_comb begin
		corr_sat = 1'b0;
		if (neg_q) begin
			if (prod_k > dpid_pkg::CORR_NEG_MAX) begin
				corr_sat = 1'b1;
				corr_new = {1'b1, {(CB-1){1'b0}}};
			end else begin
				corr_new = -prod_k[CB-1:0];
			end
		end else begin
			if (prod_k > dpid_pkg::CORR_POS_MAX) begin
				corr_sat = 1'b1;
				corr_new = {1'b0, {(CB-1){1'b1}}};
			end else begin
				corr_new = prod_k[CB-1:0];
			end
		end
	end

	assign pbase   = PSUM_BITS'({1'b0, base});
	assign pcorr   = PSUM_BITS'(corr_q);
	assign left_s  = pbase + pcorr;
	assign right_s = pbase - pcorr;

	always_comb begin
		left_clip = 1'b1;
		if (left_s[PSUM_BITS-1]) begin
			left_pulse_us = '0;
		end else if (|left_s[PSUM_BITS-2:PULSE_BITS]) begin
			left_pulse_us = '1;
		end else begin
			left_pulse_us = left_s[PULSE_BITS-1:0];
			left_clip     = 1'b0;
		end
	end

	always_comb begin
		right_clip = 1'b1;
		if (right_s[PSUM_BITS-1]) begin
			right_pulse_us = '0;
		end else if (|right_s[PSUM_BITS-2:PULSE_BITS]) begin
			right_pulse_us = '1;
		end else begin
			right_pulse_us = right_s[PULSE_BITS-1:0];
			right_clip     = 1'b0;
		end
	end

	assign correction = corr_q;
	assign clipped    = clip_q || left_clip || right_clip;

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			prev_q <= '0;
			clip_q <= 1'b0;
		end else begin
			if (accept) begin
				clip_q <= 1'b0;
			end else if ((ctrl.sum_upd && sum_sat) || (ctrl.corr_en && corr_sat)) begin
				clip_q <= 1'b1;
			end
			if (ctrl.sum_upd) begin
				sum_q <= sum_new;
			end
			if (ctrl.prev_upd) begin
				prev_q <= err_q;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q <= err_new;
		end
		if (ctrl.mul_sel != dpid_pkg::MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end
		unique case (ctrl.acc_op)
			dpid_pkg::ACC_LOAD_ERR: acc_q <= PROD_BITS'(err_q) <<< dpid_pkg::COEFF_FRAC;
			dpid_pkg::ACC_ADD_PROD: acc_q <= acc_q + prod_q;
			default:                acc_q <= acc_q;
		endcase
		if (ctrl.mag_en) begin
			neg_q <= acc_q[PROD_BITS-1];
			mag_q <= mag_big ? dpid_pkg::MAG_LIMIT : abs_acc[MB-1:0];
		end
		if (ctrl.corr_en) begin
			corr_q <= corr_new;
		end
	end

endmodule

/* sv/differential_drive_pid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_pid: PID steering for a two-wheeled drive
// Takes one control tick per beat and returns the servo pulse widths.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one control tick per beat: setpoint and wheel counts.
//   out_ch returns one beat per tick: left and right pulse widths, the
//   signed correction and a flag for any saturation in that tick.
//   Gains and base pulse width are written through cfg_we/cfg_index/cfg_data
//   while no tick is in flight.
//   The sequencer runs a 9-step microprogram around one shared 34x17
//   multiplier (integral, derivative and gain products in turn), and a
//   new tick is taken only at the wait step, once the previous tick has
//   been handed to the output register.
//   The output register holds a finished result while the receiver stalls;
//   the next tick is already accepted and computed behind it, and waits at
//   the last step until the register is free.
//   Reset clears the integral sum and the stored error, and loads the
//   registers with gain 5.0, integral 31/256, derivative 533/256, 1650 us.
// ----------------------------------------------------------------------------
module differential_drive_pid #(
	parameter int COUNT_BITS = dpid_pkg::COUNT_BITS_DEF,
	parameter int PULSE_BITS = dpid_pkg::PULSE_BITS_DEF,
	parameter int SUM_BITS   = dpid_pkg::SUM_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	dpid_in_if.sink                               in_ch,
	dpid_out_if.source                            out_ch,
	input  logic                                  cfg_we,
	input  logic [dpid_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [dpid_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	logic [dpid_pkg::GAIN_BITS-1:0] gain_q;
	logic [dpid_pkg::GAIN_BITS-1:0] icoeff_q;
	logic [dpid_pkg::GAIN_BITS-1:0] dcoeff_q;
	logic [PULSE_BITS-1:0]          base_q;

	dpid_pkg::ctrl_t     ctrl;
	dpid_pkg::seq_stat_t stat;
	logic                accept;
	logic                out_free;
	logic                out_load;
	logic                out_valid_q;

	logic [PULSE_BITS-1:0]                 left_d;
	logic [PULSE_BITS-1:0]                 right_d;
	logic signed [dpid_pkg::CORR_BITS-1:0] corr_d;
	logic                                  clip_d;
	logic [PULSE_BITS-1:0]                 left_q;
	logic [PULSE_BITS-1:0]                 right_q;
	logic signed [dpid_pkg::CORR_BITS-1:0] corr_q;
	logic                                  clip_q;

	assign in_ch.ready = (ctrl.cond == dpid_pkg::COND_IN_VALID);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign out_load    = ctrl.out_en && out_free;

	assign stat.in_valid = in_ch.valid;
	assign stat.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= dpid_pkg::GAIN_RESET;
			icoeff_q <= dpid_pkg::ICOEFF_RESET;
			dcoeff_q <= dpid_pkg::DCOEFF_RESET;
			base_q   <= PULSE_BITS'(dpid_pkg::BASE_PULSE_RESET);
		end else if (cfg_we) begin
			unique case (dpid_pkg::cfg_reg_t'(cfg_index))
				dpid_pkg::REG_PROP_GAIN:  gain_q   <= cfg_data;
				dpid_pkg::REG_INT_COEFF:  icoeff_q <= cfg_data;
				dpid_pkg::REG_DER_COEFF:  dcoeff_q <= cfg_data;
				dpid_pkg::REG_BASE_PULSE: base_q   <= cfg_data[PULSE_BITS-1:0];
				default:                  base_q   <= base_q;
			endcase
		end
	end

	dpid_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	dpid_dp #(
		.COUNT_BITS (COUNT_BITS),
		.PULSE_BITS (PULSE_BITS),
		.SUM_BITS   (SUM_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.accept            (accept),
		.target_difference (in_ch.target_difference),
		.right_count       (in_ch.right_count),
		.left_count        (in_ch.left_count),
		.gain              (gain_q),
		.icoeff            (icoeff_q),
		.dcoeff            (dcoeff_q),
		.base              (base_q),
		.left_pulse_us     (left_d),
		.right_pulse_us    (right_d),
		.correction        (corr_d),
		.clipped           (clip_d)
	);

	// Output register: hold the beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			left_q  <= left_d;
			right_q <= right_d;
			corr_q  <= corr_d;
			clip_q  <= clip_d;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.left_pulse_us  = left_q;
	assign out_ch.right_pulse_us = right_q;
	assign out_ch.correction     = corr_q;
	assign out_ch.clipped        = clip_q;

	a_one_tick_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("tick accepted while another is in flight");

	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##8 ctrl.out_en)
		else $error("microprogram did not reach the output step in time");

	a_symmetric_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.clipped) |->
		(({1'b0, out_ch.left_pulse_us} + {1'b0, out_ch.right_pulse_us}) == {base_q, 1'b0}))
		else $error("unclipped pulses not symmetric about the base width");

endmodule

/* sim/dpid_pulse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpid_pulse_checker: scoreboard for the differential drive PID
// Watches the tick and pulse channels and the register port. It keeps its
// own copy of the gains, the integral sum and the last error, and works out
// the pulse beat for every tick taken. Each pulse beat is then compared
// field by field with the oldest beat still owed.
// ----------------------------------------------------------------------------
module dpid_pulse_checker
	import dpid_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	dpid_in_if                        in_mon,
	dpid_out_if                       out_mon,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        fail_count,
	output int                        pending
);

	localparam int CB = COUNT_BITS_DEF;
	localparam int PB = PULSE_BITS_DEF;
	localparam int SB = SUM_BITS_DEF;

	localparam longint SUM_MAX     = (longint'(1) << (SB - 1)) - 1;
	localparam longint SUM_MIN     = -SUM_MAX - 1;
	localparam longint PULSE_MAX   = (longint'(1) << PB) - 1;
	localparam longint MAG_CAP     = longint'(1) << 32;
	localparam longint CORR_HI     = 32767;
	localparam longint CORR_LO_MAG = 32768;

	typedef struct packed {
		logic [PB-1:0]               left;
		logic [PB-1:0]               right;
		logic signed [CORR_BITS-1:0] corr;
		logic                        clip;
	} pulse_set_t;

	logic [GAIN_BITS-1:0] gain_k;
	logic [GAIN_BITS-1:0] coeff_i;
	logic [GAIN_BITS-1:0] coeff_d;
	logic [PB-1:0]        base_us;
	longint               integ_sum;
	longint               prev_err;

	pulse_set_t pulses_owed[$];
	pulse_set_t oldest;
	int         mismatches = 0;
	int         beats_seen = 0;

	assign fail_count = mismatches;

	// One control tick: update the integral and the stored error, then form
	// the signed Q16.0 correction and the two saturated pulse widths.
	function automatic pulse_set_t steer_tick(input logic signed [CB:0] tgt,
			input logic [CB-1:0] rc, input logic [CB-1:0] lc);
		pulse_set_t        r;
		longint            err;
		longint            acc;
		longint            corr;
		longint            lp;
		longint            rp;
		longint unsigned   mag;
		longint unsigned   prod;
		logic              clip;
		clip = 1'b0;
		err = longint'(tgt) - (longint'(rc) - longint'(lc));

		integ_sum = integ_sum + err;
		if (integ_sum > SUM_MAX) begin
			integ_sum = SUM_MAX;
			clip = 1'b1;
		end else if (integ_sum < SUM_MIN) begin
			integ_sum = SUM_MIN;
			clip = 1'b1;
		end

		acc = err * 256 + integ_sum * longint'(coeff_i)
			+ (err - prev_err) * longint'(coeff_d);
		prev_err = err;

		mag = (acc < 0) ? longint'(-acc) : acc;
		if (mag > MAG_CAP)
			mag = MAG_CAP;
		prod = (mag * longint'(gain_k)) >> 16;

		if (acc < 0) begin
			if (prod > CORR_LO_MAG) begin
				prod = CORR_LO_MAG;
				clip = 1'b1;
			end
			corr = -longint'(prod);
		end else begin
			if (prod > CORR_HI) begin
				prod = CORR_HI;
				clip = 1'b1;
			end
			corr = longint'(prod);
		end

		// positive correction lengthens the left pulse
		lp = longint'(base_us) + corr;
		rp = longint'(base_us) - corr;
		if (lp < 0) begin
			lp = 0;
			clip = 1'b1;
		end else if (lp > PULSE_MAX) begin
			lp = PULSE_MAX;
			clip = 1'b1;
		end
		if (rp < 0) begin
			rp = 0;
			clip = 1'b1;
		end else if (rp > PULSE_MAX) begin
			rp = PULSE_MAX;
			clip = 1'b1;
		end

		r.left  = lp[PB-1:0];
		r.right = rp[PB-1:0];
		r.corr  = corr[CORR_BITS-1:0];
		r.clip  = clip;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("pulse beat %0d: %s is %0d, should be %0d", beats_seen, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_k    = GAIN_RESET;
			coeff_i   = ICOEFF_RESET;
			coeff_d   = DCOEFF_RESET;
			base_us   = PB'(BASE_PULSE_RESET);
			integ_sum = 0;
			prev_err  = 0;
			pulses_owed.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_PROP_GAIN:  gain_k  = cfg_data;
					REG_INT_COEFF:  coeff_i = cfg_data;
					REG_DER_COEFF:  coeff_d = cfg_data;
					REG_BASE_PULSE: base_us = cfg_data[PB-1:0];
					default: ;
				endcase
			end

			if (in_mon.valid && in_mon.ready)
				pulses_owed.push_back(steer_tick(in_mon.target_difference,
					in_mon.right_count, in_mon.left_count));

			if (out_mon.valid && out_mon.ready) begin
				if (pulses_owed.size() == 0) begin
					report_mismatch("beat with no tick owed", 1, 0);
				end else begin
					oldest = pulses_owed.pop_front();
					if (out_mon.left_pulse_us !== oldest.left)
						report_mismatch("left_pulse_us", longint'(out_mon.left_pulse_us),
							longint'(oldest.left));
					if (out_mon.right_pulse_us !== oldest.right)
						report_mismatch("right_pulse_us", longint'(out_mon.right_pulse_us),
							longint'(oldest.right));
					if (out_mon.correction !== oldest.corr)
						report_mismatch("correction", longint'(out_mon.correction),
							longint'(oldest.corr));
					if (out_mon.clipped !== oldest.clip)
						report_mismatch("clipped", longint'(out_mon.clipped),
							longint'(oldest.clip));
				end
				beats_seen++;
			end

			pending <= pulses_owed.size();
		end
	end

endmodule

/* sim/differential_drive_pid_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_pid_test: top of the PID steering testbench
// Drives control ticks in bursts against a stalling receiver, steps the
// registers through several settings between phases, and runs a stretch at
// the largest error that builds up the integral sum. The scoreboard beside
// the block checks every pulse beat; this module only gives the verdict.
// ----------------------------------------------------------------------------
module differential_drive_pid_test;
	import dpid_pkg::*;

	localparam int CB            = COUNT_BITS_DEF;
	localparam int RESET_CYCLES  = 9;
	localparam int SEGMENTS      = 6;
	localparam int SEG_TICKS     = 228;
	localparam int SOAK_TICKS    = 40;
	localparam int LONG_HOLD     = 400;
	localparam int TAIL_CYCLES   = 40;
	localparam int CYCLE_LIMIT   = 3000000;

	localparam logic signed [CB:0] TGT_MAX = (CB + 1)'(2 ** CB - 1);
	localparam logic signed [CB:0] TGT_MIN = (CB + 1)'(-(2 ** CB));
	localparam logic [CB-1:0]      CNT_MAX = CB'(2 ** CB - 1);

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	dpid_in_if  in_ch ();
	dpid_out_if out_ch ();

	int fail_count;
	int pending;

	int max_gap;
	int burst_left;
	bit rx_quiet;
	int hold_requests;
	int holds_done;
	int cycles;

	int   run_left;
	int   stall_pct;
	int   pattern_age;
	logic rx_level;

	logic signed [CB:0] tgt_r;
	logic [CB-1:0]      rc_r;
	logic [CB-1:0]      lc_r;
	int                 seg;
	int                 n;

	differential_drive_pid dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dpid_pulse_checker pulse_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Offer one tick; open a new burst after a random gap when the last one ran out
	task automatic send_tick(input logic signed [CB:0] tgt, input logic [CB-1:0] rc,
			input logic [CB-1:0] lc);
		int gap;
		bit taken;
		if (burst_left == 0) begin
			gap = (max_gap > 0) ? int'($urandom_range(max_gap)) : 0;
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(12, 1);
		end
		burst_left--;
		in_ch.valid             <= 1'b1;
		in_ch.target_difference <= tgt;
		in_ch.right_count       <= rc;
		in_ch.left_count        <= lc;
		do begin
			@(negedge clk);
			taken = in_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic stop_sending();
		in_ch.valid <= 1'b0;
		burst_left = 0;
	endtask

	// Hold until the scoreboard owes nothing; its count is registered and lags the queue
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic load_settings(input logic [CFG_DATA_BITS-1:0] k,
			input logic [CFG_DATA_BITS-1:0] ic, input logic [CFG_DATA_BITS-1:0] dc,
			input logic [CFG_DATA_BITS-1:0] base_word);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PROP_GAIN;
		cfg_data  <= k;
		@(posedge clk);
		cfg_index <= REG_INT_COEFF;
		cfg_data  <= ic;
		@(posedge clk);
		cfg_index <= REG_DER_COEFF;
		cfg_data  <= dc;
		@(posedge clk);
		cfg_index <= REG_BASE_PULSE;
		cfg_data  <= base_word;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic pick_tick(output logic signed [CB:0] tgt, output logic [CB-1:0] rc,
			output logic [CB-1:0] lc);
		int roll;
		int near;
		roll = $urandom_range(99);
		tgt  = (CB + 1)'($urandom_range(2 ** (CB + 1) - 1));
		rc   = CB'($urandom_range(2 ** CB - 1));
		lc   = CB'($urandom_range(2 ** CB - 1));
		if (roll < 60) begin
			// keep the count difference near the setpoint so the error stays small
			near = int'(lc) + int'(tgt) + int'($urandom_range(6)) - 3;
			if (near < 0)
				near = 0;
			if (near > int'(CNT_MAX))
				near = int'(CNT_MAX);
			rc = CB'(near);
		end else if (roll < 70) begin
			tgt = ($urandom_range(1) != 0) ? TGT_MAX : TGT_MIN;
			rc  = ($urandom_range(1) != 0) ? CNT_MAX : '0;
			lc  = ($urandom_range(1) != 0) ? CNT_MAX : '0;
		end
	endtask

	// Receiver: runs of ready and stall whose mix drifts, plus long holds on request
	initial begin
		out_ch.ready = 1'b0;
		run_left     = 0;
		stall_pct    = 30;
		pattern_age  = 0;
		rx_level     = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			pattern_age++;
			if (pattern_age >= 256) begin
				pattern_age = 0;
				case ($urandom_range(4))
					0, 1: stall_pct = 0;
					2: stall_pct = 25;
					3: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			if (hold_requests != holds_done) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
				holds_done++;
			end else if (rx_quiet) begin
				out_ch.ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					rx_level = (int'($urandom_range(99)) >= stall_pct);
					run_left = $urandom_range(8, 1);
				end
				run_left--;
				out_ch.ready <= rx_level;
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n                  = 1'b0;
		cfg_we                  = 1'b0;
		cfg_index               = REG_PROP_GAIN;
		cfg_data                = '0;
		in_ch.valid             = 1'b0;
		in_ch.target_difference = '0;
		in_ch.right_count       = '0;
		in_ch.left_count        = '0;
		max_gap                 = 3;
		burst_left              = 0;
		rx_quiet                = 1'b0;
		hold_requests           = 0;
		holds_done              = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// error extremes under the reset gains
		send_tick('0, '0, '0);
		send_tick(TGT_MAX, '0, CNT_MAX);
		send_tick(TGT_MIN, CNT_MAX, '0);
		send_tick(TGT_MAX, CNT_MAX, CNT_MAX);
		send_tick(TGT_MIN, '0, '0);
		send_tick('0, CNT_MAX, '0);
		send_tick('0, '0, CNT_MAX);
		send_tick((CB + 1)'(-1), CB'(42), CB'(21));
		stop_sending();
		drain();

		// all registers at full scale; base bits above the register are dropped
		load_settings('1, '1, '1, '1);
		send_tick(TGT_MAX, '0, CNT_MAX);
		send_tick(TGT_MIN, CNT_MAX, '0);
		send_tick('0, '0, '0);
		stop_sending();
		drain();

		// unity gain against both pulse rails, both signs of correction
		load_settings(16'd256, '0, '0, '0);
		send_tick((CB + 1)'(10), '0, '0);
		send_tick((CB + 1)'(-10), '0, '0);
		stop_sending();
		drain();
		load_settings(16'd256, '0, '0, 16'h0FFF);
		send_tick((CB + 1)'(10), '0, '0);
		send_tick((CB + 1)'(-10), '0, '0);
		stop_sending();
		drain();

		// zero gain leaves the pulses at base
		load_settings('0, ICOEFF_RESET, DCOEFF_RESET, CFG_DATA_BITS'(BASE_PULSE_RESET));
		send_tick(TGT_MAX, '0, CNT_MAX);
		send_tick(TGT_MIN, CNT_MAX, '0);
		stop_sending();
		drain();

		for (seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: begin
					load_settings(GAIN_RESET, ICOEFF_RESET, DCOEFF_RESET,
						CFG_DATA_BITS'(BASE_PULSE_RESET));
					max_gap = 4;
				end
				1: begin
					load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
					max_gap = 12;
				end
				2: begin
					load_settings(16'($urandom_range(2047)), 16'($urandom_range(63)),
						16'($urandom_range(1023)), 16'($urandom_range(3000, 1000)));
					max_gap = 2;
				end
				3: begin
					load_settings('1, '1, '1, '1);
					max_gap = 0;
				end
				4: begin
					load_settings('0, '0, '0, '0);
					max_gap = 20;
				end
				default: begin
					load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
					max_gap = 6;
				end
			endcase
			for (n = 0; n < SEG_TICKS; n++) begin
				// long receiver hold while ticks keep coming: the block must back up
				if (seg == 1 && n == 0)
					hold_requests++;
				if (seg == 2 && n == SEG_TICKS / 2) begin
					stop_sending();
					drain();
				end
				pick_tick(tgt_r, rc_r, lc_r);
				send_tick(tgt_r, rc_r, lc_r);
			end
			stop_sending();
			drain();
		end

		// run at the largest error so the integral sum builds up
		load_settings('0, '0, '0, CFG_DATA_BITS'(BASE_PULSE_RESET));
		rx_quiet = 1'b1;
		max_gap  = 0;
		repeat (SOAK_TICKS) send_tick(TGT_MAX, '0, CNT_MAX);
		stop_sending();
		drain();

		// built-up sum against full integral weight, zero then minimal gain
		load_settings('0, '1, '0, CFG_DATA_BITS'(BASE_PULSE_RESET));
		send_tick(TGT_MAX, '0, CNT_MAX);
		send_tick(TGT_MIN, CNT_MAX, '0);
		stop_sending();
		drain();
		load_settings(16'd1, '1, '0, CFG_DATA_BITS'(BASE_PULSE_RESET));
		send_tick(TGT_MAX, '0, CNT_MAX);
		send_tick(TGT_MIN, CNT_MAX, '0);
		stop_sending();
		drain();

		load_settings(GAIN_RESET, ICOEFF_RESET, DCOEFF_RESET,
			CFG_DATA_BITS'(BASE_PULSE_RESET));
		rx_quiet = 1'b0;
		max_gap  = 6;
		repeat (4) send_tick(TGT_MIN, CNT_MAX, '0);
		repeat (20) begin
			pick_tick(tgt_r, rc_r, lc_r);
			send_tick(tgt_r, rc_r, lc_r);
		end
		stop_sending();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
